// ===== design/srq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and helpers for the segment reassembly queue.
// No dependencies; every other file imports this package.
package srq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned SEQ_W = 32;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned TAG_W = 16;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic clr;
    logic cmp;
    logic ins;
    logic shl;
  } cell_ctrl_t;

  // serial-number order: a precedes b when the 32-bit difference is negative
  function automatic logic serial_less(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] diff;
    diff = a - b;
    return diff[SEQ_W-1];
  endfunction

endpackage

// ===== design/srq_seg_if.sv =====
`timescale 1ns / 1ps
// Segment input channel: valid/ready plus one received segment per word.
// Depends on srq_pkg.
interface srq_seg_if import srq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seg_seq;
  logic [LEN_W-1:0] seg_len;
  logic [TAG_W-1:0] packet_tag;

  modport source (output valid, seg_seq, seg_len, packet_tag, input ready);
  modport sink   (input valid, seg_seq, seg_len, packet_tag, output ready);
endinterface

// ===== design/srq_res_if.sv =====
`timescale 1ns / 1ps
// Result channel: deliveries and the closing status word of each segment.
// Depends on srq_pkg.
interface srq_res_if import srq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             deliver;
  logic [TAG_W-1:0] out_tag;
  logic [SEQ_W-1:0] out_seq;
  logic [LEN_W-1:0] out_len;
  logic [SEQ_W-1:0] next_expected_now;
  logic             ack_now;
  logic             delayed_ack;
  logic             consumed;
  logic             notify_read;
  logic             duplicate;
  logic             overflow_drop;
  logic             last;

  modport source (output valid, deliver, out_tag, out_seq, out_len, next_expected_now,
                  ack_now, delayed_ack, consumed, notify_read, duplicate,
                  overflow_drop, last, input ready);
  modport sink   (input valid, deliver, out_tag, out_seq, out_len, next_expected_now,
                  ack_now, delayed_ack, consumed, notify_read, duplicate,
                  overflow_drop, last, output ready);
endinterface

// ===== design/srq_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel carrying the start sequence register.
// Depends on srq_pkg.
interface srq_cfg_if import srq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] start_seq;

  modport source (output valid, start_seq, input ready);
  modport sink   (input valid, start_seq, output ready);
endinterface

// ===== design/srq_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted reorder chain: holds an entry, compares it with the
// segment under work, and takes data from its left or right neighbor. Uses srq_pkg.
module srq_cell import srq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     key_i,
  input  entry_t     left_i,
  input  logic       left_valid_i,
  input  entry_t     right_i,
  input  logic       right_valid_i,
  input  logic       pick_i,
  input  logic       above_i,
  output entry_t     ent_o,
  output logic       valid_o,
  output logic       lt_o,
  output logic       eq_o
);

  logic   valid_q;
  entry_t ent_q;
  logic   lt_q;
  logic   eq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.ins && pick_i) begin
      valid_q <= 1'b1;
    end else if (ctrl_i.ins && above_i) begin
      valid_q <= left_valid_i;
    end else if (ctrl_i.shl) begin
      valid_q <= right_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp) begin
      lt_q <= valid_q && serial_less(ent_q.seq, key_i.seq);
      eq_q <= (ent_q.seq == key_i.seq);
    end
    if (ctrl_i.ins && pick_i) begin
      ent_q <= key_i;
    end else if (ctrl_i.ins && above_i) begin
      ent_q <= left_i;
    end else if (ctrl_i.shl) begin
      ent_q <= right_i;
    end
  end

  assign ent_o   = ent_q;
  assign valid_o = valid_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

// ===== design/srq_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: takes segments and config writes, picks the insert slot, drives
// the cell chain, tracks next expected and registers each result word. Uses srq_pkg.
module srq_ctrl import srq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  srq_seg_if.sink                seg_i,
  srq_res_if.source              res_o,
  srq_cfg_if.sink                cfg_i,
  input  logic [QUEUE_DEPTH-1:0] valid_i,
  input  logic [QUEUE_DEPTH-1:0] lt_i,
  input  logic [QUEUE_DEPTH-1:0] eq_i,
  input  entry_t                 head_i,
  output entry_t                 key_o,
  output cell_ctrl_t             cell_ctrl_o,
  output logic [QUEUE_DEPTH-1:0] pick_o,
  output logic [QUEUE_DEPTH-1:0] above_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_FAST,
    S_INS,
    S_DRAIN,
    S_STAT
  } state_e;

  typedef struct packed {
    logic ack_now;
    logic delayed_ack;
    logic consumed;
    logic notify;
    logic dup;
    logic ovf;
  } flags_t;

  typedef struct packed {
    logic             deliver;
    logic [TAG_W-1:0] tag;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] nexp;
    flags_t           flags;
    logic             last;
  } res_t;

  state_e           state_q;
  entry_t           key_q;
  logic [SEQ_W-1:0] nexp_q;
  flags_t           flags_q;
  logic             out_valid_q;
  logic             out_valid_d;
  res_t             res_q;
  res_t             res_d;

  logic [QUEUE_DEPTH:0] lt_x;
  logic [QUEUE_DEPTH:0] pick_x;
  logic [QUEUE_DEPTH:0] above_x;
  logic                 dup;
  logic                 full;
  logic                 slot_free;
  logic                 head_hit;
  logic                 fast;
  logic                 cfg_wr;
  logic                 seg_acc;
  logic [SEQ_W-1:0]     key_sum;
  logic [SEQ_W-1:0]     head_sum;

  // first slot whose entry is not serial-less than the segment
  assign lt_x    = {1'b0, lt_i};
  assign pick_x  = ~lt_x & (lt_x + 1'b1);
  assign above_x = ~(pick_x | (pick_x - 1'b1));
  assign pick_o  = pick_x[QUEUE_DEPTH-1:0];
  assign above_o = above_x[QUEUE_DEPTH-1:0];

  assign dup       = |(pick_o & eq_i & valid_i);
  assign full      = valid_i[QUEUE_DEPTH-1];
  assign slot_free = !out_valid_q || res_o.ready;
  assign head_hit  = valid_i[0] && (head_i.seq == nexp_q);
  assign fast      = (key_q.seq == nexp_q) && !valid_i[0];
  assign cfg_wr    = cfg_i.valid && cfg_i.ready;
  assign seg_acc   = seg_i.valid && seg_i.ready;
  assign key_sum   = nexp_q + {{(SEQ_W-LEN_W){1'b0}}, key_q.len};
  assign head_sum  = nexp_q + {{(SEQ_W-LEN_W){1'b0}}, head_i.len};

  // a pending config write has priority over a segment
  assign seg_i.ready = (state_q == S_IDLE) && !cfg_i.valid;
  assign cfg_i.ready = (state_q == S_IDLE) && !out_valid_q;

  assign key_o           = key_q;
  assign cell_ctrl_o.clr = cfg_wr;
  assign cell_ctrl_o.cmp = (state_q == S_CMP);
  assign cell_ctrl_o.ins = (state_q == S_INS) && !dup && !full;
  assign cell_ctrl_o.shl = (state_q == S_DRAIN) && head_hit && slot_free;

  assign res_o.valid             = out_valid_q;
  assign res_o.deliver           = res_q.deliver;
  assign res_o.out_tag           = res_q.tag;
  assign res_o.out_seq           = res_q.seq;
  assign res_o.out_len           = res_q.len;
  assign res_o.next_expected_now = res_q.nexp;
  assign res_o.ack_now           = res_q.flags.ack_now;
  assign res_o.delayed_ack       = res_q.flags.delayed_ack;
  assign res_o.consumed          = res_q.flags.consumed;
  assign res_o.notify_read       = res_q.flags.notify;
  assign res_o.duplicate         = res_q.flags.dup;
  assign res_o.overflow_drop     = res_q.flags.ovf;
  assign res_o.last              = res_q.last;

  always_comb begin
    out_valid_d = out_valid_q && !res_o.ready;
    res_d       = res_q;
    case (state_q)
      S_FAST: begin
        if (slot_free) begin
          out_valid_d   = 1'b1;
          res_d         = '0;
          res_d.deliver = 1'b1;
          res_d.tag     = key_q.tag;
          res_d.seq     = key_q.seq;
          res_d.len     = key_q.len;
          res_d.nexp    = key_sum;
        end
      end
      S_DRAIN: begin
        if (head_hit && slot_free) begin
          out_valid_d   = 1'b1;
          res_d         = '0;
          res_d.deliver = 1'b1;
          res_d.tag     = head_i.tag;
          res_d.seq     = head_i.seq;
          res_d.len     = head_i.len;
          res_d.nexp    = head_sum;
        end
      end
      S_STAT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          res_d       = '0;
          res_d.nexp  = nexp_q;
          res_d.flags = flags_q;
          res_d.last  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_q       <= '0;
      nexp_q      <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
      case (state_q)
        S_IDLE: begin
          if (cfg_wr) begin
            nexp_q <= cfg_i.start_seq;
          end else if (seg_acc) begin
            key_q   <= '{seq: seg_i.seg_seq, len: seg_i.seg_len, tag: seg_i.packet_tag};
            flags_q <= '0;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= fast ? S_FAST : S_INS;
        end
        S_FAST: begin
          if (slot_free) begin
            nexp_q               <= key_sum;
            flags_q.delayed_ack  <= 1'b1;
            flags_q.consumed     <= 1'b1;
            flags_q.notify       <= (key_q.len != '0);
            state_q              <= S_STAT;
          end
        end
        S_INS: begin
          flags_q.ack_now <= 1'b1;
          if (dup) begin
            flags_q.dup <= 1'b1;
            state_q     <= S_STAT;
          end else if (full) begin
            flags_q.ovf <= 1'b1;
            state_q     <= S_STAT;
          end else begin
            flags_q.consumed <= 1'b1;
            state_q          <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (head_hit) begin
            if (slot_free) begin
              nexp_q <= head_sum;
              if (head_i.len != '0) begin
                flags_q.notify <= 1'b1;
              end
            end
          end else begin
            state_q <= S_STAT;
          end
        end
        S_STAT: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/segment_reassembly_queue_top.sv =====
`timescale 1ns / 1ps
// Top level of the segment reassembly queue: sequencer plus a chain of cells.
// Depends on srq_pkg, the three channel interfaces, srq_ctrl and srq_cell.
//
// Keeps the next expected sequence number and up to QUEUE_DEPTH out-of-order
// segments sorted in serial-number order, one segment per cell of a chain.
// Each accepted segment yields zero or more delivery words (deliver = 1) and
// one closing status word (last = 1) with the ack, consumed, notify, duplicate
// and overflow flags. All cells compare against the new segment at once, and
// the insert shifts the chain right by one in the next state, and each in-order
// head is delivered by a left shift of the chain, one word per cycle while the
// result channel does not stall. A fast in-order segment passes S_CMP, S_FAST
// and S_STAT, a dropped one S_CMP, S_INS and S_STAT, and a queued one S_CMP,
// S_INS, S_DRAIN and S_STAT. A start_seq write loads the next expected
// number and empties the queue; it is taken only while no segment is in work
// and no result word waits, and a pending write holds off the segment channel.
module segment_reassembly_queue_top import srq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  srq_seg_if.sink   seg_i,
  srq_res_if.source res_o,
  srq_cfg_if.sink   cfg_i
);

  entry_t                 ents [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid;
  logic [QUEUE_DEPTH-1:0] lt;
  logic [QUEUE_DEPTH-1:0] eq;
  logic [QUEUE_DEPTH-1:0] pick;
  logic [QUEUE_DEPTH-1:0] above;
  entry_t                 key;
  cell_ctrl_t             cell_ctrl;

  srq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_i       (seg_i),
    .res_o       (res_o),
    .cfg_i       (cfg_i),
    .valid_i     (valid),
    .lt_i        (lt),
    .eq_i        (eq),
    .head_i      (ents[0]),
    .key_o       (key),
    .cell_ctrl_o (cell_ctrl),
    .pick_o      (pick),
    .above_o     (above)
  );

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    entry_t left_ent;
    logic   left_vld;
    entry_t right_ent;
    logic   right_vld;

    if (k == 0) begin : g_first
      assign left_ent = '0;
      assign left_vld = 1'b0;
    end else begin : g_mid_l
      assign left_ent = ents[k-1];
      assign left_vld = valid[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = '0;
      assign right_vld = 1'b0;
    end else begin : g_mid_r
      assign right_ent = ents[k+1];
      assign right_vld = valid[k+1];
    end

    srq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .key_i         (key),
      .left_i        (left_ent),
      .left_valid_i  (left_vld),
      .right_i       (right_ent),
      .right_valid_i (right_vld),
      .pick_i        (pick[k]),
      .above_i       (above[k]),
      .ent_o         (ents[k]),
      .valid_o       (valid[k]),
      .lt_o          (lt[k]),
      .eq_o          (eq[k])
    );
  end

endmodule

// ===== design/srq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the result channel of the reassembly queue, bound to
// the top level. Depends on srq_pkg and segment_reassembly_queue_top.
module srq_checker import srq_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic             deliver_i,
  input logic [TAG_W-1:0] out_tag_i,
  input logic [SEQ_W-1:0] out_seq_i,
  input logic [SEQ_W-1:0] next_expected_now_i,
  input logic             ack_now_i,
  input logic             delayed_ack_i,
  input logic             consumed_i,
  input logic             notify_read_i,
  input logic             duplicate_i,
  input logic             overflow_drop_i,
  input logic             last_i
);

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(out_seq_i) &&
      $stable(out_tag_i) && $stable(last_i) && $stable(next_expected_now_i))
    else $error("result word changed while stalled");

  // every word is either a delivery or the status word, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> deliver_i != last_i)
    else $error("word is neither or both delivery and status");

  // flags appear only on the status word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && deliver_i |-> !(ack_now_i || delayed_ack_i || consumed_i ||
      notify_read_i || duplicate_i || overflow_drop_i))
    else $error("status flag on a delivery word");

  // exactly one kind of ack per segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && last_i |-> ack_now_i != delayed_ack_i)
    else $error("status word must request exactly one ack kind");

  // a dropped segment is neither kept nor advances the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && last_i && (duplicate_i || overflow_drop_i) |->
      !consumed_i && !notify_read_i && ack_now_i)
    else $error("dropped segment reported as consumed");

endmodule

bind segment_reassembly_queue_top srq_checker u_srq_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .res_valid_i         (res_o.valid),
  .res_ready_i         (res_o.ready),
  .deliver_i           (res_o.deliver),
  .out_tag_i           (res_o.out_tag),
  .out_seq_i           (res_o.out_seq),
  .next_expected_now_i (res_o.next_expected_now),
  .ack_now_i           (res_o.ack_now),
  .delayed_ack_i       (res_o.delayed_ack),
  .consumed_i          (res_o.consumed),
  .notify_read_i       (res_o.notify_read),
  .duplicate_i         (res_o.duplicate),
  .overflow_drop_i     (res_o.overflow_drop),
  .last_i              (res_o.last)
);

// ===== tb/segment_reassembly_queue_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for segment_reassembly_queue_top: a directed table, then random segment bursts.
// Every result word is checked against a reassembly model kept inside the bench.
// Depends on srq_pkg, srq_seg_if, srq_res_if, srq_cfg_if and the RTL top.
module segment_reassembly_queue_top_tb;
  import srq_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
  localparam int unsigned IDLE_PCT = 27;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 42;
  localparam int unsigned NOISE_ITEMS = 6;

  typedef struct packed {
    logic ack_now;
    logic delayed_ack;
    logic consumed;
    logic notify_read;
    logic duplicate;
    logic overflow_drop;
  } status_t;

  localparam status_t ST_NONE = '0;
  localparam status_t ST_FAST_EMPTY = '{delayed_ack: 1'b1, consumed: 1'b1, default: 1'b0};
  localparam status_t ST_FAST_READ =
    '{delayed_ack: 1'b1, consumed: 1'b1, notify_read: 1'b1, default: 1'b0};
  localparam status_t ST_QUEUED = '{ack_now: 1'b1, consumed: 1'b1, default: 1'b0};
  localparam status_t ST_DUP = '{ack_now: 1'b1, duplicate: 1'b1, default: 1'b0};
  localparam status_t ST_DROP = '{ack_now: 1'b1, overflow_drop: 1'b1, default: 1'b0};

  typedef enum logic {ROW_SEG, ROW_CFG} row_kind_e;

  // for ROW_CFG the seq column carries the start sequence
  typedef struct {
    row_kind_e   kind;
    logic [31:0] seq;
    logic [15:0] len;
    logic [15:0] tag;
    logic        typed;
    status_t     st;
    logic [31:0] nxt;
  } dir_row_t;

  typedef struct {
    logic [31:0] seq;
    logic [15:0] len;
    logic [15:0] tag;
  } held_seg_t;

  typedef struct {
    logic        deliver;
    logic [15:0] tag;
    logic [31:0] seq;
    logic [15:0] len;
    logic [31:0] nxt;
    status_t     st;
    logic        last;
  } res_word_t;

  logic clk_i;
  logic rst_ni;
  int   n_fail = 0;
  bit   steady = 1'b0;

  res_word_t   expected_words[$];
  held_seg_t   reorder_q[$];
  logic [31:0] rcv_next;

  srq_seg_if seg ();
  srq_res_if res ();
  srq_cfg_if cfg ();

  segment_reassembly_queue_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic seq_older(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  task automatic push_delivery(input logic [31:0] seq, input logic [15:0] len,
                               input logic [15:0] tag);
    res_word_t w;
    w.deliver = 1'b1;
    w.tag = tag;
    w.seq = seq;
    w.len = len;
    w.nxt = rcv_next;
    w.st = ST_NONE;
    w.last = 1'b0;
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic reassemble(input logic [31:0] seq, input logic [15:0] len,
                            input logic [15:0] tag);
    res_word_t   w;
    held_seg_t   e;
    status_t     st;
    int          pos;
    logic [31:0] prior;
    st = ST_NONE;
    if (seq == rcv_next && reorder_q.size() == 0) begin
      rcv_next += len;
      push_delivery(seq, len, tag);
      st.delayed_ack = 1'b1;
      st.consumed = 1'b1;
      st.notify_read = (len != 0);
    end else begin
      st.ack_now = 1'b1;
      pos = 0;
      while (pos < reorder_q.size() && seq_older(reorder_q[pos].seq, seq)) pos++;
      if (pos < reorder_q.size() && reorder_q[pos].seq == seq) begin
        st.duplicate = 1'b1;
      end else if (reorder_q.size() >= DEPTH) begin
        st.overflow_drop = 1'b1;
      end else begin
        e.seq = seq;
        e.len = len;
        e.tag = tag;
        reorder_q.insert(pos, e);
        st.consumed = 1'b1;
        prior = rcv_next;
        while (reorder_q.size() > 0 && reorder_q[0].seq == rcv_next) begin
          e = reorder_q.pop_front();
          rcv_next += e.len;
          push_delivery(e.seq, e.len, e.tag);
        end
        st.notify_read = (rcv_next != prior);
      end
    end
    w.deliver = 1'b0;
    w.tag = '0;
    w.seq = '0;
    w.len = '0;
    w.nxt = rcv_next;
    w.st = st;
    w.last = 1'b1;
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic send_seg(input logic [31:0] seq, input logic [15:0] len,
                          input logic [15:0] tag);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      seg.valid <= 1'b0;
      @(posedge clk_i);
    end
    seg.valid <= 1'b1;
    seg.seg_seq <= seq;
    seg.seg_len <= len;
    seg.packet_tag <= tag;
    @(posedge clk_i);
    while (!seg.ready) @(posedge clk_i);
    reassemble(seq, len, tag);
  endtask

  // only once every expected word is back, so the block is idle
  task automatic write_start(input logic [31:0] value);
    seg.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.start_seq <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    rcv_next = value;
    reorder_q.delete();
  endtask

  function automatic logic [15:0] rand_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return 16'($urandom_range(16'hFFFF));
    return 16'($urandom_range(1, 1500));
  endfunction

  function automatic logic [31:0] noise_seq();
    case ($urandom_range(3))
      0: return $urandom;
      1: return rcv_next - $urandom_range(1, 5000);
      2: return rcv_next + 32'h8000_0000;
      default: begin
        if (reorder_q.size() == 0) return $urandom;
        return reorder_q[$urandom_range(0, reorder_q.size() - 1)].seq;
      end
    endcase
  endfunction

  task automatic random_phase(input logic [31:0] start_val);
    held_seg_t   burst[$];
    held_seg_t   e;
    held_seg_t   head;
    int          n;
    int          k;
    int          j;
    int          items;
    logic [31:0] at;
    write_start(start_val);
    items = 0;
    while (items < PHASE_ITEMS - NOISE_ITEMS) begin
      n = (items == 0) ? DEPTH : $urandom_range(1, DEPTH);
      burst.delete();
      at = rcv_next;
      for (k = 0; k < n; k++) begin
        e.seq = at;
        e.len = rand_len();
        e.tag = 16'($urandom);
        at += e.len;
        burst.insert(burst.size(), e);
      end
      head = burst.pop_front();
      for (k = burst.size() - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        e = burst[k];
        burst[k] = burst[j];
        burst[j] = e;
      end
      // a full burst sends its in-order head last: longest drain
      burst.insert((n == DEPTH) ? n - 1 : $urandom_range(0, n - 1), head);
      k = $urandom_range(99);
      if (k < 10) burst.delete($urandom_range(0, burst.size() - 1));
      else if (k < 20)
        burst.insert(burst.size(), burst[$urandom_range(0, burst.size() - 1)]);
      foreach (burst[i]) begin
        send_seg(burst[i].seq, burst[i].len, burst[i].tag);
        items++;
      end
    end
    // stale and far segments block the drain, so they close the phase
    repeat (NOISE_ITEMS) send_seg(noise_seq(), rand_len(), 16'($urandom));
  endtask

  initial begin
    int        idle;
    res_word_t w;
    idle = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ((seg.valid && seg.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        idle = 0;
      else
        idle++;
      if (res.valid && res.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with none expected: deliver=%0b seq=%h last=%0b",
                 res.deliver, res.out_seq, res.last);
          n_fail++;
        end else begin
          w = expected_words.pop_front();
          check_field("deliver", w.deliver, res.deliver);
          check_field("out_tag", w.tag, res.out_tag);
          check_field("out_seq", w.seq, res.out_seq);
          check_field("out_len", w.len, res.out_len);
          check_field("next_expected_now", w.nxt, res.next_expected_now);
          check_field("ack_now", w.st.ack_now, res.ack_now);
          check_field("delayed_ack", w.st.delayed_ack, res.delayed_ack);
          check_field("consumed", w.st.consumed, res.consumed);
          check_field("notify_read", w.st.notify_read, res.notify_read);
          check_field("duplicate", w.st.duplicate, res.duplicate);
          check_field("overflow_drop", w.st.overflow_drop, res.overflow_drop);
          check_field("last", w.last, res.last);
        end
      end
      if (idle >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
      res.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  initial begin
    dir_row_t    rows[$];
    logic [31:0] starts[5];
    int          k;
    rst_ni <= 1'b0;
    seg.valid <= 1'b0;
    seg.seg_seq <= '0;
    seg.seg_len <= '0;
    seg.packet_tag <= '0;
    cfg.valid <= 1'b0;
    cfg.start_seq <= '0;
    rcv_next = '0;

    rows.insert(rows.size(),
                '{ROW_SEG, 32'h0000_0000, 16'h0000, 16'hFFFF, 1'b1, ST_FAST_EMPTY, 32'h0});
    rows.insert(rows.size(),
                '{ROW_SEG, 32'h0000_0000, 16'hFFFF, 16'h0000, 1'b1, ST_FAST_READ,
                  32'h0000_FFFF});
    rows.insert(rows.size(),
                '{ROW_SEG, 32'h0001_0063, 16'd10, 16'd1, 1'b1, ST_QUEUED, 32'h0000_FFFF});
    rows.insert(rows.size(),
                '{ROW_SEG, 32'h0001_0063, 16'd7, 16'd2, 1'b1, ST_DUP, 32'h0000_FFFF});
    // exactly half the sequence space away from the queued entry
    rows.insert(rows.size(),
                '{ROW_SEG, 32'h8001_0063, 16'd5, 16'd3, 1'b0, ST_NONE, 32'h0});
    rows.insert(rows.size(),
                '{ROW_SEG, 32'h0000_FFFF, 16'd100, 16'd5, 1'b0, ST_NONE, 32'h0});
    rows.insert(rows.size(),
                '{ROW_SEG, 32'h0000_0005, 16'd3, 16'd4, 1'b0, ST_NONE, 32'h0});
    // fill across the wrap, then hit the full queue
    rows.insert(rows.size(),
                '{ROW_CFG, 32'hFFFF_FFF0, 16'd0, 16'd0, 1'b0, ST_NONE, 32'h0});
    for (k = 1; k <= DEPTH; k++)
      rows.insert(rows.size(),
                  '{ROW_SEG, 32'hFFFF_FFF0 + k, 16'd1, k[15:0], 1'b0, ST_NONE, 32'h0});
    rows.insert(rows.size(),
                '{ROW_SEG, 32'h0000_0054, 16'd1, 16'hA5A5, 1'b1, ST_DROP, 32'hFFFF_FFF0});
    rows.insert(rows.size(),
                '{ROW_SEG, 32'hFFFF_FFF4, 16'd1, 16'h5A5A, 1'b1, ST_DUP, 32'hFFFF_FFF0});

    starts[0] = 32'hFFFF_FFFF;
    starts[1] = 32'h0000_0000;
    starts[2] = 32'h8000_0000;
    starts[3] = $urandom;
    starts[4] = $urandom;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_start(rows[i].seq);
      end else begin
        send_seg(rows[i].seq, rows[i].len, rows[i].tag);
        if (rows[i].typed) begin
          expected_words[$].st = rows[i].st;
          expected_words[$].nxt = rows[i].nxt;
        end
      end
    end

    for (k = 0; k < 5; k++) begin
      steady = (k == 1);
      random_phase(starts[k]);
    end
    steady = 1'b0;

    seg.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
